// ===== design/lmc_pkg.sv =====
// Package with the shared constants, widths and codes of the LIS membership classifier.
`timescale 1ns / 1ps
package lmc_pkg;
  localparam int MAX_LEN = 1024;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int CNT_W   = IDX_W + 1;
  localparam int VAL_W   = 32;
  // Element word: {value, end rank, excluded flag}.
  localparam int ELEM_W  = VAL_W + IDX_W + 1;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_SOME = 2'd1,
    CLS_ALL  = 2'd2
  } cls_t;
endpackage

// ===== design/lmc_if.sv =====
// Request and result channel interfaces of the LIS membership classifier.
`timescale 1ns / 1ps
interface lmc_in_if
  import lmc_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [31:0] value;
  logic               last;
  logic [9:0]         index;
  modport source (output valid, operation, value, last, index, input ready);
  modport sink   (input valid, operation, value, last, index, output ready);
endinterface

interface lmc_out_if
  import lmc_pkg::*;
  ();
  logic        valid;
  logic        ready;
  logic [1:0]  element_class;
  logic [10:0] lis_length;
  logic        index_error;
  modport source (output valid, element_class, lis_length, index_error, input ready);
  modport sink   (input valid, element_class, lis_length, index_error, output ready);
endinterface

// ===== design/lmc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module lmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/lis_membership_classifier_top.sv =====
// Top level of the LIS membership classifier: sequencer and its three memories.
//
// Usage: requests arrive on in_ch (valid/ready). A push request stores one
// signed value; once MAX_LEN values are held, further values are dropped.
// The push marked last closes the sequence and starts classification: a
// clearing sweep of the rank-count memory over the loaded elements, a
// forward pass and a backward pass. Each pass fetches each element in S_RD
// and S_LD, runs S_SRCH and S_CMP for each binary-search step over the
// tails memory (at most about log2(n) steps), closes the search in S_SRCH
// and writes in S_WR; in the backward pass an element on a longest path
// also passes through S_RC_RD and S_RC_WR for a rank-count increment.
// in_ch.ready is low during classification. A query request reads its
// element and the rank count and loads its result into the output register
// through S_Q1, S_Q2 and S_QOUT, or straight from S_QOUT for an
// out-of-range index or an open sequence; pushes give no result. The
// result sits in an output register, so a stalled receiver does not keep
// the block from accepting pushes; a second query waits until the register
// is free. Synchronous active-low reset empties the sequence and drops any
// pending result; memory contents are not cleared by reset.
`timescale 1ns / 1ps
module lis_membership_classifier_top
  import lmc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  lmc_in_if.sink    in_ch,
  lmc_out_if.source out_ch
);
  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_RD, S_LD, S_SRCH, S_CMP, S_WR, S_RC_RD, S_RC_WR,
    S_Q1, S_Q2, S_QOUT
  } state_t;

  state_t              state_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                sealed_r;
  logic [IDX_W-1:0]    longest_r;
  logic [IDX_W-1:0]    top_r;
  logic [IDX_W-1:0]    i_r;
  logic [CNT_W-1:0]    lo_r;
  logic [CNT_W-1:0]    hi_r;
  logic                bwd_r;
  logic signed [VAL_W-1:0] v_r;
  logic [IDX_W-1:0]    er_r;
  logic                qexcl_r;
  logic [1:0]          qcls_r;
  logic                qerr_r;
  logic [CNT_W-1:0]    qlen_r;
  logic                out_valid_r;
  logic [1:0]          out_cls_r;
  logic [CNT_W-1:0]    out_len_r;
  logic                out_err_r;

  // Memory ports.
  logic                e_we;
  logic [IDX_W-1:0]    e_waddr, e_raddr;
  logic [ELEM_W-1:0]   e_wdata, e_rdata;
  logic                t_we;
  logic [IDX_W-1:0]    t_waddr, t_raddr;
  logic [VAL_W-1:0]    t_wdata, t_rdata;
  logic                r_we;
  logic [IDX_W-1:0]    r_waddr, r_raddr;
  logic [CNT_W-1:0]    r_wdata, r_rdata;

  logic                accept;
  logic                is_push;
  logic [CNT_W-1:0]    cnt_m1;
  logic                at_end;
  logic [CNT_W-1:0]    mid;
  logic                excl;
  logic                hit;
  logic signed [VAL_W-1:0] t_val;

  assign accept  = in_ch.valid && in_ch.ready;
  assign is_push = (in_ch.operation == OP_PUSH);
  assign in_ch.ready = (state_r == S_IDLE);
  assign cnt_m1  = cnt_r - CNT_W'(1);
  assign at_end  = ({1'b0, i_r} == cnt_m1);
  assign mid     = CNT_W'((lo_r + hi_r) >> 1);
  assign excl    = (({1'b0, lo_r[IDX_W-1:0]} + {1'b0, er_r}) < {1'b0, longest_r});
  assign t_val   = $signed(t_rdata);
  // Forward pass looks for the first tail >= v, backward for the first tail <= v.
  assign hit     = bwd_r ? (t_val <= v_r) : (t_val >= v_r);

  assign out_ch.valid         = out_valid_r;
  assign out_ch.element_class = out_cls_r;
  assign out_ch.lis_length    = out_len_r;
  assign out_ch.index_error   = out_err_r;

  always_comb begin
    e_we    = 1'b0;
    e_waddr = i_r;
    e_wdata = {v_r, (bwd_r ? er_r : lo_r[IDX_W-1:0]), (bwd_r ? excl : 1'b0)};
    e_raddr = (state_r == S_IDLE) ? in_ch.index : i_r;
    t_we    = 1'b0;
    t_waddr = lo_r[IDX_W-1:0];
    t_wdata = v_r;
    t_raddr = mid[IDX_W-1:0];
    r_we    = 1'b0;
    r_waddr = (state_r == S_CLR) ? i_r : er_r;
    r_wdata = (state_r == S_CLR) ? '0 : r_rdata + CNT_W'(1);
    r_raddr = (state_r == S_Q1) ? e_rdata[IDX_W:1] : er_r;
    if (state_r == S_IDLE && accept && is_push) begin
      // A push into a classified sequence starts a new one at entry zero.
      e_we    = sealed_r || (cnt_r < CNT_W'(MAX_LEN));
      e_waddr = sealed_r ? '0 : cnt_r[IDX_W-1:0];
      e_wdata = {in_ch.value, {(IDX_W + 1){1'b0}}};
    end
    if (state_r == S_WR) begin
      e_we = 1'b1;
      t_we = 1'b1;
    end
    if (state_r == S_CLR || state_r == S_RC_WR) begin
      r_we = 1'b1;
    end
  end

  lmc_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_LEN)) u_elem_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  lmc_ram #(.WIDTH(VAL_W), .DEPTH(MAX_LEN)) u_tails_ram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  lmc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_LEN)) u_rank_ram (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sealed_r    <= 1'b0;
      longest_r   <= '0;
      top_r       <= '0;
      i_r         <= '0;
      bwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // The result stage reloads the register itself while it waits.
      if (out_ch.ready && state_r != S_QOUT) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept && is_push) begin
            if (sealed_r) begin
              cnt_r     <= CNT_W'(1);
              longest_r <= '0;
            end else if (cnt_r < CNT_W'(MAX_LEN)) begin
              cnt_r <= cnt_r + CNT_W'(1);
            end
            sealed_r <= in_ch.last;
            if (in_ch.last) begin
              i_r     <= '0;
              state_r <= S_CLR;
            end
          end else if (accept) begin
            qlen_r  <= sealed_r ? {1'b0, longest_r} + CNT_W'(1) : '0;
            qcls_r  <= CLS_NONE;
            if (sealed_r && ({1'b0, in_ch.index} < cnt_r)) begin
              qerr_r  <= 1'b0;
              state_r <= S_Q1;
            end else begin
              qerr_r  <= 1'b1;
              state_r <= S_QOUT;
            end
          end
        end
        S_CLR: begin
          if (at_end) begin
            i_r     <= '0;
            top_r   <= '0;
            bwd_r   <= 1'b0;
            state_r <= S_RD;
          end else begin
            i_r <= i_r + IDX_W'(1);
          end
        end
        S_RD: begin
          state_r <= S_LD;
        end
        S_LD: begin
          v_r  <= $signed(e_rdata[ELEM_W-1:IDX_W+1]);
          er_r <= e_rdata[IDX_W:1];
          lo_r <= '0;
          // The first element of either pass takes slot zero without a search.
          if (bwd_r ? at_end : (i_r == '0)) begin
            hi_r <= '0;
          end else begin
            hi_r <= {1'b0, top_r} + CNT_W'(1);
          end
          state_r <= S_SRCH;
        end
        S_SRCH: begin
          state_r <= (lo_r < hi_r) ? S_CMP : S_WR;
        end
        S_CMP: begin
          if (hit) begin
            hi_r <= mid;
          end else begin
            lo_r <= mid + CNT_W'(1);
          end
          state_r <= S_SRCH;
        end
        S_WR: begin
          if (!bwd_r) begin
            if (at_end) begin
              longest_r <= (lo_r[IDX_W-1:0] > top_r) ? lo_r[IDX_W-1:0] : top_r;
              top_r     <= '0;
              bwd_r     <= 1'b1;
            end else begin
              if (lo_r[IDX_W-1:0] > top_r) begin
                top_r <= lo_r[IDX_W-1:0];
              end
              i_r <= i_r + IDX_W'(1);
            end
            state_r <= S_RD;
          end else begin
            if (lo_r[IDX_W-1:0] > top_r) begin
              top_r <= lo_r[IDX_W-1:0];
            end
            if (!excl) begin
              state_r <= S_RC_RD;
            end else if (i_r == '0) begin
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_r - IDX_W'(1);
              state_r <= S_RD;
            end
          end
        end
        S_RC_RD: begin
          state_r <= S_RC_WR;
        end
        S_RC_WR: begin
          if (i_r == '0) begin
            state_r <= S_IDLE;
          end else begin
            i_r     <= i_r - IDX_W'(1);
            state_r <= S_RD;
          end
        end
        S_Q1: begin
          qexcl_r <= e_rdata[0];
          state_r <= S_Q2;
        end
        S_Q2: begin
          if (qexcl_r) begin
            qcls_r <= CLS_NONE;
          end else if (r_rdata == CNT_W'(1)) begin
            qcls_r <= CLS_ALL;
          end else begin
            qcls_r <= CLS_SOME;
          end
          state_r <= S_QOUT;
        end
        S_QOUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_cls_r   <= qcls_r;
            out_len_r   <= qlen_r;
            out_err_r   <= qerr_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== design/lmc_checker.sv =====
// Port-level checker of the LIS membership classifier and its bind statement.
`timescale 1ns / 1ps
module lmc_checker
  import lmc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_class,
  input logic [10:0] out_len,
  input logic        out_err
);
  a_err_no_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_err |-> out_class == CLS_NONE)
    else $error("index error result carries a class");

  a_class_has_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_class != CLS_NONE |-> out_len != 11'd0)
    else $error("member class reported with zero length");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_len <= 11'(MAX_LEN) && out_class != 2'd3)
    else $error("result out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_class) && $stable(out_len)
      && $stable(out_err))
    else $error("stalled result changed");
endmodule

bind lis_membership_classifier_top lmc_checker u_lmc_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_class(out_ch.element_class), .out_len(out_ch.lis_length),
  .out_err(out_ch.index_error)
);
